// File: design/ccc_pkg.sv
// Shared types, constants and calendar helper functions for the calendar clock counter.
`default_nettype none

package ccc_pkg;

  // Kind of an input item, carried on tuser.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SHIFT = 2'd1,
    ACT_LOAD  = 2'd2
  } action_e;

  // Configuration register indexes.
  localparam logic CFG_STEP_SECONDS   = 1'b0;
  localparam logic CFG_TICKS_PER_STEP = 1'b1;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 72;

  localparam logic [6:0] SecondsPerMinute = 7'd60;
  localparam logic [6:0] MinutesPerHour   = 7'd60;
  localparam logic [5:0] HoursPerDay      = 6'd24;
  localparam logic [4:0] MonthsPerYear    = 5'd12;
  localparam logic [3:0] DaysPerWeek      = 4'd7;

  // Fields of one input item apart from the action.
  typedef struct packed {
    logic signed [5:0] shift_hours;
    logic [7:0]        set_year;
    logic [3:0]        set_month;
    logic [4:0]        set_day;
    logic [4:0]        set_hour;
    logic [5:0]        set_minute;
    logic [5:0]        set_second;
    logic [2:0]        set_weekday;
  } load_t;

  typedef struct packed {
    action_e action;
    load_t   load;
  } item_t;

  // Complete clock state.
  typedef struct packed {
    logic [15:0] prescale;
    logic [31:0] uptime;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [7:0]  year;
    logic [2:0]  weekday;
  } clk_state_t;

  // Length of the current month; February follows the four-year leap rule.
  function automatic logic [5:0] days_in_month(input logic [3:0] month,
                                               input logic [7:0] year);
    logic [5:0] len;
    unique case (month)
      4'd3, 4'd5, 4'd8, 4'd10: len = 6'd30;
      4'd1:                    len = (year[1:0] != 2'b00) ? 6'd28 : 6'd29;
      default:                 len = 6'd31;
    endcase
    return len;
  endfunction

  // Reduces a value below 120 to its remainder modulo 24.
  function automatic logic [4:0] wrap_hour(input logic [6:0] v);
    logic [6:0] r;
    priority if (v >= 7'd96) r = v - 7'd96;
    else if (v >= 7'd72)     r = v - 7'd72;
    else if (v >= 7'd48)     r = v - 7'd48;
    else if (v >= 7'd24)     r = v - 7'd24;
    else                     r = v;
    return r[4:0];
  endfunction

endpackage

`default_nettype wire

// File: design/ccc_step.sv
// Next-state logic of the clock: prescaler, time and date cascade, hour shift and load.
`default_nettype none

module ccc_step (
  input  wire ccc_pkg::clk_state_t state_i,
  input  wire ccc_pkg::item_t      item_i,
  input  wire logic [5:0]          step_seconds_i,
  input  wire logic [15:0]         ticks_per_step_i,
  output ccc_pkg::clk_state_t      state_o,
  output logic                     minute_event_o
);

  logic [15:0] pre_inc;
  logic        do_step;
  logic [6:0]  sec_sum;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic [3:0]  wday_inc;
  logic [8:0]  hour_sum;

  assign pre_inc   = state_i.prescale + 16'd1;
  assign do_step   = (pre_inc >= ticks_per_step_i);
  assign sec_sum   = {1'b0, state_i.second} + {1'b0, step_seconds_i};
  assign min_inc   = {1'b0, state_i.minute} + 7'd1;
  assign hour_inc  = {1'b0, state_i.hour} + 6'd1;
  assign day_inc   = {1'b0, state_i.day} + 6'd1;
  assign month_inc = {1'b0, state_i.month} + 5'd1;
  assign wday_inc  = {1'b0, state_i.weekday} + 4'd1;
  // Offset by 48 so that the signed sum is never negative before the wrap.
  assign hour_sum  = {4'b0, state_i.hour} + {{3{item_i.load.shift_hours[5]}},
                     item_i.load.shift_hours} + 9'd48;

  always_comb begin
    state_o        = state_i;
    minute_event_o = 1'b0;
    unique case (item_i.action)
      ccc_pkg::ACT_TICK: begin
        state_o.prescale = pre_inc;
        if (do_step) begin
          state_o.prescale = 16'd0;
          state_o.uptime   = state_i.uptime + {26'd0, step_seconds_i};
          if (state_i.year != 8'd0) begin
            if (sec_sum < ccc_pkg::SecondsPerMinute) begin
              state_o.second = sec_sum[5:0];
            end else begin
              state_o.second = 6'd0;
              minute_event_o = 1'b1;
              state_o.minute = min_inc[5:0];
              if (min_inc >= ccc_pkg::MinutesPerHour) begin
                state_o.minute = 6'd0;
                state_o.hour   = hour_inc[4:0];
                if (hour_inc >= ccc_pkg::HoursPerDay) begin
                  state_o.hour    = 5'd0;
                  state_o.day     = day_inc[4:0];
                  state_o.weekday = wday_inc[2:0];
                  if (wday_inc >= ccc_pkg::DaysPerWeek) begin
                    state_o.weekday = 3'd0;
                  end
                  if (day_inc >= ccc_pkg::days_in_month(state_i.month, state_i.year)) begin
                    state_o.day   = 5'd0;
                    state_o.month = month_inc[3:0];
                    if (month_inc >= ccc_pkg::MonthsPerYear) begin
                      state_o.month = 4'd0;
                      state_o.year  = state_i.year + 8'd1;
                    end
                  end
                end
              end
            end
          end
        end
      end
      ccc_pkg::ACT_SHIFT: begin
        state_o.hour = ccc_pkg::wrap_hour(hour_sum[6:0]);
      end
      ccc_pkg::ACT_LOAD: begin
        state_o.year    = item_i.load.set_year;
        state_o.month   = item_i.load.set_month;
        state_o.day     = item_i.load.set_day;
        state_o.hour    = item_i.load.set_hour;
        state_o.minute  = item_i.load.set_minute;
        state_o.second  = item_i.load.set_second;
        state_o.weekday = item_i.load.set_weekday;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/calendar_clock_counter.sv
// Top level of the calendar clock counter: input stage, clock state and result register.
//
// The block keeps a real-time clock and calendar. Each item on the slave stream is a
// tick (tuser 0), a signed hour shift (tuser 1) or a date load (tuser 2); tuser 3 is
// ignored. Every item produces exactly one result item on the master stream holding
// the full calendar, the minute event flag and the uptime as they stand after it.
// A tick advances the prescaler; when it reaches ticks_per_step one clock step adds
// step_seconds to the uptime and, while the year is nonzero, to the seconds, which
// clear on reaching 60 and carry through minute, hour, day, month and year. An hour
// shift wraps modulo 24. An accepted item is held in the input register, then the
// next-state logic updates the state and the result register together. Throughput is
// one item per cycle while the receiver keeps up; the state feedback through one
// cascade of small adders and compares is the only loop. When the receiver stalls the
// result register holds, the input register fills, and then tready drops; nothing is
// lost. Reset clears the state (year zero, so the calendar is stopped until a load)
// and sets both configuration registers to one. Configuration is written through a
// plain write port: index 0 is step_seconds, index 1 is ticks_per_step.
`default_nettype none

module calendar_clock_counter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_addr_i,
  input  wire logic [ccc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input items.
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata from bit 0: shift_hours, set_year, set_month, set_day, set_hour,
  // set_minute, set_second, set_weekday, zero padding.
  input  wire logic [ccc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: action.
  input  wire logic [1:0]                   s_axis_tuser_i,
  // Result items.
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // tdata from bit 0: year, month, day, hour, minute, second, weekday,
  // minute_event, uptime_seconds, zero padding.
  output logic [ccc_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  logic [5:0]  step_seconds_q;
  logic [15:0] ticks_per_step_q;

  logic             s1_valid_q;
  ccc_pkg::item_t   s1_item_q;
  logic             s1_adv;
  ccc_pkg::load_t   in_load;

  ccc_pkg::clk_state_t state_q;
  ccc_pkg::clk_state_t state_d;
  logic                event_d;

  logic                         out_valid_q;
  logic [ccc_pkg::OutDataW-1:0] out_data_q;
  logic [ccc_pkg::OutDataW-1:0] out_data_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_seconds_q   <= 6'd1;
      ticks_per_step_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ccc_pkg::CFG_STEP_SECONDS:   step_seconds_q   <= cfg_wdata_i[5:0];
        ccc_pkg::CFG_TICKS_PER_STEP: ticks_per_step_q <= cfg_wdata_i[15:0];
        default:                     step_seconds_q   <= step_seconds_q;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or being drained.
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  assign in_load.shift_hours = s_axis_tdata_i[5:0];
  assign in_load.set_year    = s_axis_tdata_i[13:6];
  assign in_load.set_month   = s_axis_tdata_i[17:14];
  assign in_load.set_day     = s_axis_tdata_i[22:18];
  assign in_load.set_hour    = s_axis_tdata_i[27:23];
  assign in_load.set_minute  = s_axis_tdata_i[33:28];
  assign in_load.set_second  = s_axis_tdata_i[39:34];
  assign in_load.set_weekday = s_axis_tdata_i[42:40];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_item_q.action <= ccc_pkg::action_e'(s_axis_tuser_i);
      s1_item_q.load   <= in_load;
    end
  end

  ccc_step u_step (
    .state_i          (state_q),
    .item_i           (s1_item_q),
    .step_seconds_i   (step_seconds_q),
    .ticks_per_step_i (ticks_per_step_q),
    .state_o          (state_d),
    .minute_event_o   (event_d)
  );

  // The clock state only changes when an item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  assign out_data_d = {2'b00, state_d.uptime, event_d, state_d.weekday, state_d.second,
                       state_d.minute, state_d.hour, state_d.day, state_d.month,
                       state_d.year};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // A minute event always leaves the seconds at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[37]) |-> (m_axis_tdata_o[33:28] == 6'd0))
    else $error("minute event with nonzero seconds");

  // A held item in the input register is never dropped while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("stalled item lost from input register");

  // Clock state does not move without an item leaving the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(s1_adv) |-> $stable(state_q))
    else $error("clock state changed without an item");

endmodule

`default_nettype wire
